FILE: rtl/core/frh_pkg.sv
// Shared types and codes for the ring-history FIR filter.
// No dependencies; used by frh_mac and fir_filter_ring_history_top.
package frh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_t;

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  localparam logic REG_ACTIVE_TAPS  = 1'b0;
  localparam logic REG_PRELOAD_MODE = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
  } mac_ctrl_t;

endpackage

FILE: rtl/core/frh_mac.sv
// Shared multiply-accumulate unit: registered product, saturating accumulator.
// Depends on frh_pkg for the control struct.
module frh_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16,
  parameter int ACC_W       = 38
) (
  input  logic                          clk,
  input  logic                          rst,
  input  frh_pkg::mac_ctrl_t            ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample_op,
  input  logic signed [COEF_BITS-1:0]   weight_op,
  output logic signed [ACC_W-1:0]       acc,
  output logic                          pending
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int SUM_W  = ACC_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((66'sd1 <<< (ACC_W - 1)) - 66'sd1);
  localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;

  logic signed [PROD_W-1:0] prod;
  logic                     mul_v;
  logic signed [SUM_W-1:0]  sum;

  assign pending = mul_v;
  assign sum     = SUM_W'(acc) + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= ctrl.load;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod <= sample_op * weight_op;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (mul_v) begin
      if (sum > SUM_HI) begin
        acc <= ACC_W'(SUM_HI);
      end else if (sum < SUM_LO) begin
        acc <= ACC_W'(SUM_LO);
      end else begin
        acc <= ACC_W'(sum);
      end
    end
  end

endmodule

FILE: rtl/core/fir_filter_ring_history_top.sv
// Ring-history direct-form FIR filter, top level; depends on frh_pkg and frh_mac.
// Coefficient writes: may follow each other every cycle while no sample is in progress; no result.
// Sample: one shared multiply-accumulate walks n taps, one tap per cycle (n = taps in use);
// then the pipeline drains, the sum is rounded and loaded into the output register; the next
// transaction is taken only after that load, so a stalled result holds the next one.
// Reset: weights and history read as zero, 32 taps, preload off; no clearing pass.
module fir_filter_ring_history_top #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [4:0]                    tap_index,
  input  logic signed [COEF_BITS-1:0]   coefficient,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          block_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] filtered_sample,
  output logic                          saturated,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [5:0]                    cfg_data
);

  localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int N_W    = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int SUM_W0 = PROD_W + $clog2(MAX_TAPS + 1);
  localparam int ACC_W  = (SUM_W0 > 64) ? 64 : SUM_W0;
  localparam int FRAC   = COEF_BITS - 2;
  localparam int TW     = ACC_W - FRAC;
  localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((64'sd1 <<< FRAC) - 64'sd1);
  localparam logic signed [TW-1:0]    Y_HI = TW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [TW-1:0]    Y_LO = -Y_HI - TW'(1);

  function automatic logic [N_W-1:0] taps_of(input logic [5:0] v);
    if (v == 6'd0) begin
      return N_W'(1);
    end else if (int'(v) > MAX_TAPS) begin
      return N_W'(MAX_TAPS);
    end else begin
      return N_W'(v);
    end
  endfunction

  frh_pkg::state_t    state, state_next;
  frh_pkg::mac_ctrl_t mac_ctrl;

  logic [5:0]       active_taps;
  logic             preload_mode;
  logic [IDX_W-1:0] newest_slot;
  logic [N_W-1:0]   n_use;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] slot;

  logic [MAX_TAPS-1:0] tap_valid;
  logic [MAX_TAPS-1:0] hist_valid;
  logic signed [COEF_BITS-1:0]   tap_mem  [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] fill_value;
  logic [N_W-1:0]                fill_n;

  logic [IDX_W-1:0] tap_i;
  logic [IDX_W-1:0] hist_j;
  logic             rd_v;
  logic             issue;
  logic signed [COEF_BITS-1:0]   w_q;
  logic signed [SAMPLE_BITS-1:0] h_q;
  logic                          w_v_q;
  logic                          h_v_q;
  logic                          fill_q;
  logic signed [COEF_BITS-1:0]   w_val;
  logic signed [SAMPLE_BITS-1:0] h_val;

  logic signed [ACC_W-1:0] acc;
  logic                    mac_pending;
  logic signed [ACC_W-1:0] biased;
  logic signed [TW-1:0]    trunc_q;

  logic accept;
  logic accept_coef;
  logic accept_sample;
  logic out_free;
  logic load_out;
  logic coef_in_range;

  assign n_use         = taps_of(active_taps);
  assign last          = IDX_W'(n_use - N_W'(1));
  assign slot          = block_start ? last : newest_slot;
  assign accept        = in_valid && !in_stall;
  assign accept_coef   = accept && (operation == frh_pkg::OP_COEF);
  assign accept_sample = accept && (operation == frh_pkg::OP_FILTER);
  assign out_free      = !out_valid || !out_stall;
  assign coef_in_range = int'(tap_index) < MAX_TAPS;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      frh_pkg::ST_IDLE:  if (accept_sample) state_next = frh_pkg::ST_READ;
      frh_pkg::ST_READ:  if (tap_i == last) state_next = frh_pkg::ST_DRAIN;
      frh_pkg::ST_DRAIN: if (!rd_v && !mac_pending) state_next = frh_pkg::ST_ROUND;
      frh_pkg::ST_ROUND: state_next = frh_pkg::ST_EMIT;
      frh_pkg::ST_EMIT:  if (out_free) state_next = frh_pkg::ST_IDLE;
      default:           state_next = frh_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall       = (state != frh_pkg::ST_IDLE);
    issue          = (state == frh_pkg::ST_READ);
    load_out       = (state == frh_pkg::ST_EMIT) && out_free;
    mac_ctrl.clear = accept_sample;
    mac_ctrl.load  = rd_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration, ring pointer, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps  <= 6'd32;
      preload_mode <= 1'b0;
      newest_slot  <= IDX_W'(taps_of(6'd32) - N_W'(1));
      tap_valid    <= '0;
      hist_valid   <= '0;
      fill_value   <= '0;
      fill_n       <= '0;
    end else begin
      if (accept_coef && coef_in_range) begin
        tap_valid[IDX_W'(tap_index)] <= 1'b1;
      end
      if (accept_sample) begin
        if (block_start) begin
          hist_valid <= MAX_TAPS'(1) << slot;
          fill_value <= preload_mode ? sample : '0;
          fill_n     <= n_use;
        end else begin
          hist_valid[slot] <= 1'b1;
        end
        newest_slot <= (slot == '0) ? last : slot - IDX_W'(1);
      end
      if (cfg_write) begin
        if (cfg_index == frh_pkg::REG_ACTIVE_TAPS) begin
          active_taps <= cfg_data;
          newest_slot <= IDX_W'(taps_of(cfg_data) - N_W'(1));
        end else begin
          preload_mode <= cfg_data[0];
        end
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept_coef && coef_in_range) begin
      tap_mem[IDX_W'(tap_index)] <= coefficient;
    end
    if (issue) begin
      w_q <= tap_mem[tap_i];
    end
  end

  always_ff @(posedge clk) begin
    if (accept_sample) begin
      hist_mem[slot] <= sample;
    end
    if (issue) begin
      h_q <= hist_mem[hist_j];
    end
  end

  // tap walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_sample) begin
      tap_i  <= '0;
      hist_j <= slot;
    end else if (issue) begin
      tap_i  <= tap_i + IDX_W'(1);
      hist_j <= (hist_j == last) ? '0 : hist_j + IDX_W'(1);
    end
    if (issue) begin
      w_v_q  <= tap_valid[tap_i];
      h_v_q  <= hist_valid[hist_j];
      fill_q <= N_W'(hist_j) < fill_n;
    end
  end

  assign w_val = w_v_q ? w_q : '0;
  assign h_val = h_v_q ? h_q : (fill_q ? fill_value : '0);

  frh_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .sample_op (h_val),
    .weight_op (w_val),
    .acc       (acc),
    .pending   (mac_pending)
  );

  // truncate toward zero
  assign biased = acc + (acc[ACC_W-1] ? BIAS : '0);

  always_ff @(posedge clk) begin
    if (state == frh_pkg::ST_ROUND) begin
      trunc_q <= TW'(biased >>> FRAC);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (trunc_q > Y_HI) begin
        filtered_sample <= SAMPLE_BITS'(Y_HI);
        saturated       <= 1'b1;
      end else if (trunc_q < Y_LO) begin
        filtered_sample <= SAMPLE_BITS'(Y_LO);
        saturated       <= 1'b1;
      end else begin
        filtered_sample <= SAMPLE_BITS'(trunc_q);
        saturated       <= 1'b0;
      end
    end
  end

endmodule

FILE: verif/tb_fir_filter_ring_history_top.sv
// Self-checking testbench for fir_filter_ring_history_top (ring-history FIR filter).
// Directed table then randomised phases, each output checked against an in-bench model or a value typed in the table.
// Depends on frh_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb_fir_filter_ring_history_top;

  localparam int MAX_TAPS   = 32;
  localparam int FRAC_BITS  = 14;
  localparam int IDLE_TAIL  = 40;
  localparam int WDOG_LIMIT = 4000;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 120;

  typedef struct packed {
    logic               op;
    logic [4:0]         idx;
    logic signed [15:0] coef;
    logic signed [15:0] samp;
    logic               bs;
    logic               typed;
    logic signed [15:0] want_value;
    logic               want_sat;
  } item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               sat;
  } filt_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] filtered_sample;
  logic        saturated;
  logic        cfg_write = 1'b0;
  logic        cfg_index = frh_pkg::REG_ACTIVE_TAPS;
  logic [5:0]  cfg_data = '0;
  item_t       cur = '0;

  // filter model state
  logic signed [15:0] tap_w [MAX_TAPS];
  logic signed [15:0] hist [MAX_TAPS];
  int          head;
  logic [5:0]  taps_cfg;
  logic        preload_cfg;
  filt_out_t   expected_outputs [$];

  int          errors = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  int          roll;
  logic        steady = 1'b0;
  logic        wide_coefs = 1'b1;
  item_t       script [$];

  fir_filter_ring_history_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (cur.op),
    .tap_index       (cur.idx),
    .coefficient     (cur.coef),
    .sample          (cur.samp),
    .block_start     (cur.bs),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .filtered_sample (filtered_sample),
    .saturated       (saturated),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int taps_used();
    if (taps_cfg == 0) return 1;
    if (taps_cfg > MAX_TAPS) return MAX_TAPS;
    return int'(taps_cfg);
  endfunction

  function automatic void model_reset();
    int i;
    for (i = 0; i < MAX_TAPS; i++) begin
      tap_w[i] = '0;
      hist[i]  = '0;
    end
    taps_cfg    = 6'd32;
    preload_cfg = 1'b0;
    head        = taps_used() - 1;
    expected_outputs.delete();
  endfunction

  function automatic void model_config(logic index, logic [5:0] data);
    if (index == frh_pkg::REG_ACTIVE_TAPS) begin
      taps_cfg = data;
      head     = taps_used() - 1;
    end else begin
      preload_cfg = data[0];
    end
  endfunction

  function automatic filt_out_t filter_sample(logic signed [15:0] x, logic bs);
    int        n;
    int        i;
    int        j;
    longint    acc;
    longint    y;
    filt_out_t r;
    n = taps_used();
    if (head >= n) head = n - 1;
    if (bs) begin
      for (i = 0; i < MAX_TAPS; i++)
        hist[i] = (preload_cfg && i < n) ? x : 16'sd0;
      head = n - 1;
    end
    hist[head] = x;
    acc = 0;
    for (i = 0; i < n; i++) begin
      j = head + i;
      if (j >= n) j -= n;
      acc += longint'(hist[j]) * longint'(tap_w[i]);
    end
    head = (head == 0) ? n - 1 : head - 1;
    // truncate toward zero, then clamp to 16 bits
    y = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
    r.sat = 1'b0;
    if (y > 32767) begin
      y = 32767;
      r.sat = 1'b1;
    end
    if (y < -32768) begin
      y = -32768;
      r.sat = 1'b1;
    end
    r.value = y[15:0];
    return r;
  endfunction

  function automatic void model_item(item_t it);
    filt_out_t r;
    if (it.op == frh_pkg::OP_COEF) begin
      tap_w[it.idx] = it.coef;
    end else begin
      r = filter_sample(it.samp, it.bs);
      if (it.typed) begin
        r.value = it.want_value;
        r.sat   = it.want_sat;
      end
      expected_outputs.push_back(r);
    end
  endfunction

  // checking and prediction, on values from before the edge
  always @(posedge clk) begin
    if (rst) begin
      model_reset();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          errors++;
          if (errors < 200)
            $display("%0t: unexpected output transaction, value %0d sat %0b",
                     $time, filtered_sample, saturated);
        end else begin
          if (filtered_sample !== expected_outputs[0].value) begin
            errors++;
            if (errors < 200)
              $display("%0t: filtered_sample expected %0d, got %0d", $time,
                       expected_outputs[0].value, filtered_sample);
          end
          if (saturated !== expected_outputs[0].sat) begin
            errors++;
            if (errors < 200)
              $display("%0t: saturated expected %0b, got %0b", $time,
                       expected_outputs[0].sat, saturated);
          end
          void'(expected_outputs.pop_front());
        end
      end
      if (cfg_write) model_config(cfg_index, cfg_data);
      if (in_valid && !in_stall) model_item(cur);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (steady || roll < 70) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        hold_left <= (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  function automatic item_t row(logic op, int idx, int coef, int samp, logic bs,
                                logic typed, int val, logic sat);
    item_t it;
    it.op         = op;
    it.idx        = 5'(idx);
    it.coef       = 16'(coef);
    it.samp       = 16'(samp);
    it.bs         = bs;
    it.typed      = typed;
    it.want_value = 16'(val);
    it.want_sat   = sat;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    it = '0;
    it.op  = ($urandom_range(0, 99) < 15) ? frh_pkg::OP_COEF : frh_pkg::OP_FILTER;
    it.idx = 5'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 10)
      it.coef = (r < 5) ? 16'sh7fff : 16'sh8000;
    else if (wide_coefs)
      it.coef = 16'($urandom);
    else
      it.coef = 16'($urandom_range(0, 1023) - 512);
    r = $urandom_range(0, 99);
    if (r < 10)
      it.samp = (r < 5) ? 16'sh7fff : 16'sh8000;
    else
      it.samp = 16'($urandom);
    it.bs = ($urandom_range(0, 99) < 5);
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(input item_t it);
    cur      <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(input int cycles);
    item_t junk;
    if (cycles > 0) begin
      junk = random_item();
      cur      <= junk;
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_regs(input logic [5:0] taps, input logic preload);
    cfg_write <= 1'b1;
    cfg_index <= frh_pkg::REG_ACTIVE_TAPS;
    cfg_data  <= taps;
    @(posedge clk);
    cfg_index <= frh_pkg::REG_PRELOAD_MODE;
    cfg_data  <= {5'd0, preload};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int         k;
    int         p;
    int         i;
    logic [5:0] taps_plan [8];
    taps_plan = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd31, 6'd17, 6'd5};

    // reset state: 32 taps, preload off, weights and history zero
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, 32767, 0, 1, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, -32768, 0, 1, 0, 0));
    script.push_back(row(frh_pkg::OP_COEF, 0, 16384, 0, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, -32768, 1, 1, -32768, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, 32767, 0, 1, 32767, 0));
    script.push_back(row(frh_pkg::OP_COEF, 1, -32768, 0, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, 32767, 1, 1, 32767, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, -32768, 0, 1, -32768, 1));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, 32767, 0, 1, 32767, 1));
    script.push_back(row(frh_pkg::OP_COEF, 1, 0, 0, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_COEF, 31, 32767, 0, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_COEF, 0, 8191, 0, 0, 0, 0, 0));
    // truncation goes toward zero, not down
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, -3, 1, 1, -1, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, 3, 0, 1, 1, 0));
    script.push_back(row(frh_pkg::OP_COEF, 21, -16384, -1, 1, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_COEF, 10, 12000, 0, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 31, -1, 12345, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, -20000, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, 0, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_COEF, 31, -1, 0, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, 32767, 0, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, -1, 1, 0, 0, 0));
    script.push_back(row(frh_pkg::OP_FILTER, 0, 0, -32768, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < script.size(); k++) begin
      send(script[k]);
      pause(pick_gap());
    end

    for (p = 0; p < PHASES; p++) begin
      quiesce();
      steady     = ($urandom_range(0, 3) == 0);
      wide_coefs = ($urandom_range(0, 2) == 0);
      write_regs((p < 8) ? taps_plan[p] : 6'($urandom_range(1, 32)),
                 (p < 4) ? p[0] : 1'($urandom_range(0, 1)));
      for (i = 0; i < PHASE_LEN; i++) begin
        send(random_item());
        pause(pick_gap());
      end
    end

    quiesce();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
